[hdl/ebcs_pkg.sv]
`timescale 1ns / 1ps

package ebcs_pkg;

    // Crosspoint size
    localparam int NUM_ROWS    = 5;
    localparam int NUM_COLS    = 3;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 2;
    localparam int ROUTE_WIDTH = 15;
    localparam int CELL_W      = 5;

    // Field widths
    localparam int THR_W   = 4;
    localparam int DEB_W   = 8;
    localparam int LONG_W  = 16;
    localparam int TIME_W  = 32;
    localparam int ACC_W   = 5;
    localparam int STEP_W  = 2;
    localparam int EVENT_W = 2;

    // Stream and register port widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int ADDR_W     = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_STEP_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_MS    = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS_MS  = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]  THR_RESET  = 4'd4;
    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd20;
    localparam logic [LONG_W-1:0] LONG_RESET = 16'd600;

    // Button event codes
    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CLICK = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

    // Step codes, two's complement
    localparam logic [STEP_W-1:0] STEP_NONE = 2'b00;
    localparam logic [STEP_W-1:0] STEP_UP   = 2'b01;
    localparam logic [STEP_W-1:0] STEP_DOWN = 2'b11;

    typedef struct packed {
        logic [LONG_W-1:0] long_press_ms;
        logic [DEB_W-1:0]  debounce_ms;
        logic [THR_W-1:0]  step_threshold;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              switch_level;
        logic              dt_level;
        logic              clk_level;
    } sample_t;

    typedef struct packed {
        logic                   redraw;
        logic [ROUTE_WIDTH-1:0] route_bits;
        logic                   row_mode;
        logic [COL_W-1:0]       cursor_col;
        logic [ROW_W-1:0]       cursor_row;
        logic [EVENT_W-1:0]     button_event;
        logic signed [STEP_W-1:0] step_out;
    } result_t;

endpackage

[hdl/ebcs_core.sv]
`timescale 1ns / 1ps

module ebcs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  ebcs_pkg::cfg_t    cfg,
    input  logic              sample_valid,
    input  ebcs_pkg::sample_t sample,
    output ebcs_pkg::result_t result
);
    import ebcs_pkg::*;

    logic                    prev_clk_reg, prev_clk_next;
    logic signed [ACC_W-1:0] accum_reg, accum_next;
    logic                    prev_switch_reg, prev_switch_next;
    logic [TIME_W-1:0]       press_start_reg, press_start_next;
    logic [TIME_W-1:0]       last_change_reg, last_change_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic                    mode_reg, mode_next;
    logic [ROUTE_WIDTH-1:0]  route_reg, route_next;

    logic signed [ACC_W:0]   accum_sum;
    logic signed [ACC_W:0]   thr_pos;
    logic signed [ACC_W:0]   thr_neg;
    logic [STEP_W-1:0]       step;
    logic [EVENT_W-1:0]      event_code;
    logic [TIME_W-1:0]       since_change;
    logic [TIME_W-1:0]       press_len;
    logic [CELL_W-1:0]       cross_idx;

    // Accumulate encoder clock edges and issue a step at either bound
    always_comb
    begin
        thr_pos       = $signed({2'b00, cfg.step_threshold});
        thr_neg       = -thr_pos;
        accum_sum     = {accum_reg[ACC_W-1], accum_reg}
                        + ((sample.dt_level == sample.clk_level) ? -6'sd1 : 6'sd1);
        step          = STEP_NONE;
        accum_next    = accum_reg;
        prev_clk_next = sample.clk_level;
        if (sample.clk_level != prev_clk_reg)
        begin
            priority if (accum_sum >= thr_pos)
            begin
                step       = STEP_UP;
                accum_next = '0;
            end
            else if (accum_sum <= thr_neg)
            begin
                step       = STEP_DOWN;
                accum_next = '0;
            end
            else
            begin
                accum_next = accum_sum[ACC_W-1:0];
            end
        end
    end

    // Move the cursor in the current mode, with wraparound
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (step == STEP_UP)
        begin
            if (mode_reg)
                row_next = (row_reg == ROW_W'(NUM_ROWS - 1)) ? '0 : row_reg + 1'b1;
            else
                col_next = (col_reg == COL_W'(NUM_COLS - 1)) ? '0 : col_reg + 1'b1;
        end
        else if (step == STEP_DOWN)
        begin
            if (mode_reg)
                row_next = (row_reg == '0) ? ROW_W'(NUM_ROWS - 1) : row_reg - 1'b1;
            else
                col_next = (col_reg == '0) ? COL_W'(NUM_COLS - 1) : col_reg - 1'b1;
        end
    end

    // Debounce the switch and classify the press on release
    always_comb
    begin
        since_change     = sample.now_ms - last_change_reg;
        press_len        = sample.now_ms - press_start_reg;
        event_code       = EV_NONE;
        prev_switch_next = prev_switch_reg;
        last_change_next = last_change_reg;
        press_start_next = press_start_reg;
        if (since_change >= TIME_W'(cfg.debounce_ms) &&
            sample.switch_level != prev_switch_reg)
        begin
            last_change_next = sample.now_ms;
            prev_switch_next = sample.switch_level;
            if (!sample.switch_level)
                press_start_next = sample.now_ms;
            else
                event_code = (press_len >= TIME_W'(cfg.long_press_ms)) ? EV_LONG : EV_CLICK;
        end
    end

    // Apply the button event: toggle the routing bit or the mode
    always_comb
    begin
        cross_idx  = CELL_W'(row_next) * CELL_W'(NUM_COLS) + CELL_W'(col_next);
        route_next = route_reg;
        mode_next  = mode_reg;
        if (event_code == EV_CLICK && cross_idx < CELL_W'(ROUTE_WIDTH))
            route_next = route_reg ^ (ROUTE_WIDTH'(1) << cross_idx);
        if (event_code == EV_LONG)
            mode_next = ~mode_reg;
    end

    // Result for this beat
    always_comb
    begin
        result.step_out     = step;
        result.button_event = event_code;
        result.cursor_row   = row_next;
        result.cursor_col   = col_next;
        result.row_mode     = mode_next;
        result.route_bits   = route_next;
        result.redraw       = (step != STEP_NONE) || (event_code != EV_NONE);
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg    <= 1'b1;
            accum_reg       <= '0;
            prev_switch_reg <= 1'b1;
            press_start_reg <= '0;
            last_change_reg <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            mode_reg        <= 1'b0;
            route_reg       <= '0;
        end
        else if (sample_valid)
        begin
            prev_clk_reg    <= prev_clk_next;
            accum_reg       <= accum_next;
            prev_switch_reg <= prev_switch_next;
            press_start_reg <= press_start_next;
            last_change_reg <= last_change_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            mode_reg        <= mode_next;
            route_reg       <= route_next;
        end
    end

endmodule

[hdl/encoder_button_crosspoint_selector.sv]
`timescale 1ns / 1ps
// Channel    Direction  Width  Contents
// s_axis     in         40     pin sample and millisecond timestamp
// m_axis     out        32     step, button event, cursor, mode, routing map
// apb        in/out     32     step_threshold 0x0, debounce_ms 0x4, long_press_ms 0x8
//
// One sample per clock while s_axis_tready is high: the state update is combinational
// from the input beat to the result register, or to the skid register on a stall.
// A two-entry output stage (result register plus skid register) keeps s_axis_tready
// high while one result waits on m_axis; it drops only when both are full.
// rst_n clears the cursor, mode, routing map and registers to their reset values.

module encoder_button_crosspoint_selector (
    input  logic                                clk,
    input  logic                                rst_n,
    // [0] clk_level, [1] dt_level, [2] switch_level, [34:3] now_ms, rest zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ebcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] step_out, [3:2] button_event, [6:4] cursor_row, [8:7] cursor_col,
    // [9] row_mode, [24:10] route_bits, [25] redraw, rest zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ebcs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ebcs_pkg::ADDR_W-1:0]         paddr,
    input  logic [ebcs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ebcs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ebcs_pkg::*;

    localparam int RESULT_W = $bits(result_t);

    cfg_t    cfg_reg;
    sample_t sample;
    result_t result;
    logic    accept;
    logic    cfg_write;

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_threshold <= THR_RESET;
            cfg_reg.debounce_ms    <= DEB_RESET;
            cfg_reg.long_press_ms  <= LONG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_STEP_THRESHOLD: cfg_reg.step_threshold <= pwdata[THR_W-1:0];
                REG_DEBOUNCE_MS:    cfg_reg.debounce_ms    <= pwdata[DEB_W-1:0];
                REG_LONG_PRESS_MS:  cfg_reg.long_press_ms  <= pwdata[LONG_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[3:2])
            REG_STEP_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.step_threshold);
            REG_DEBOUNCE_MS:    prdata = APB_DATA_W'(cfg_reg.debounce_ms);
            REG_LONG_PRESS_MS:  prdata = APB_DATA_W'(cfg_reg.long_press_ms);
            default:            prdata = '0;
        endcase
    end

    // Unpack the input beat
    assign sample        = sample_t'(s_axis_tdata[$bits(sample_t)-1:0]);
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ebcs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (accept),
        .sample       (sample),
        .result       (result)
    );

    // Result register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_reg};

endmodule
